[rtl/fra_pkg.sv]
package fra_pkg;

  localparam int ADDR_WIDTH = 48;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [ADDR_WIDTH-1:0] range_start;
    logic [ADDR_WIDTH-1:0] range_end;
    logic [ADDR_WIDTH-1:0] alloc_size;
    logic [3:0]            align_log2;
  } fra_req_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] address;
    logic [1:0]            status;
  } fra_rsp_t;

  localparam logic [1:0] OP_FREE        = 2'd0;
  localparam logic [1:0] OP_RESERVE     = 2'd1;
  localparam logic [1:0] OP_ALLOC_AUTO  = 2'd2;
  localparam logic [1:0] OP_ALLOC_ALIGN = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int ALIGN_8  = 8;
  localparam int ALIGN_16 = 16;
  localparam int ALIGN_32 = 32;
  localparam logic [3:0] LG_8  = 4'd3;
  localparam logic [3:0] LG_16 = 4'd4;
  localparam logic [3:0] LG_32 = 4'd5;
  localparam logic [3:0] LG_64 = 4'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FIT_A,
    S_FIT_CHK,
    S_PREP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_DONE
  } fra_state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_ev;
    logic fit_a;
    logic fit_chk;
    logic prep;
    logic shift_rd;
    logic shift_wr;
    logic ins;
    logic commit;
    logic nofit;
    logic full;
  } fra_cmd_t;

  typedef struct packed {
    logic trivial;
    logic scan_end;
    logic is_alloc;
    logic skip;
    logic stop;
    logic fit_ok;
    logic zero_size;
    logic nop;
    logic full;
    logic no_shift;
    logic shift_last;
    logic ins_done;
  } fra_stat_t;

endpackage

[rtl/fra_ctrl.sv]
module fra_ctrl import fra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  fra_stat_t stat,
  output fra_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  fra_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (stat.trivial) state_next = S_DONE;
        else if (stat.scan_end) state_next = stat.is_alloc ? S_DONE : S_PREP;
        else state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (!stat.is_alloc || stat.skip) state_next = S_SCAN_RD;
        else if (stat.stop) state_next = S_DONE;
        else state_next = S_FIT_A;
      end
      S_FIT_A: state_next = S_FIT_CHK;
      S_FIT_CHK: begin
        if (!stat.fit_ok) state_next = S_SCAN_RD;
        else if (stat.zero_size) state_next = S_DONE;
        else state_next = S_PREP;
      end
      S_PREP: state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.nop || stat.full) state_next = S_DONE;
        else if (stat.no_shift) state_next = S_INS;
        else state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (stat.shift_last) state_next = S_INS;
        else state_next = S_SHIFT_RD;
      end
      S_INS: begin
        if (stat.ins_done) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.scan_rd  = (state == S_SCAN_RD);
    cmd.scan_ev  = (state == S_SCAN_EV);
    cmd.fit_a    = (state == S_FIT_A);
    cmd.fit_chk  = (state == S_FIT_CHK);
    cmd.prep     = (state == S_PREP);
    cmd.shift_rd = (state == S_SHIFT_RD);
    cmd.shift_wr = (state == S_SHIFT_WR);
    cmd.ins      = (state == S_INS) && !stat.ins_done;
    cmd.commit   = (state == S_INS) && stat.ins_done;
    cmd.nofit    = ((state == S_SCAN_RD) && !stat.trivial && stat.scan_end && stat.is_alloc)
                || ((state == S_SCAN_EV) && stat.is_alloc && !stat.skip && stat.stop);
    cmd.full     = (state == S_DECIDE) && !stat.nop && stat.full;
    busy         = (state != S_IDLE);
    done         = (state == S_DONE);
  end

endmodule

[rtl/fra_datapath.sv]
module fra_datapath import fra_pkg::*; #(
  parameter int MAX_RANGES = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  fra_req_t  request,
  input  fra_cmd_t  cmd,
  output fra_stat_t stat,
  output fra_rsp_t  result
);

  localparam int AW = ADDR_WIDTH;
  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic [2*AW-1:0] mem [MAX_RANGES];
  logic [2*AW-1:0] rd_data;

  logic [1:0]    op;
  logic [AW-1:0] s, e, size, mask;
  logic [CW-1:0] k, count, i, j, ptr;
  logic          i_found, up, ovf;
  logic [AW-1:0] cap_s, cap_e, b_r, e_r, a_r, cut_lo, cut_hi;
  logic [1:0]    n, q;
  logic [AW-1:0] p0s, p0e, p1s, p1e;
  logic [CW:0]   newcount;
  logic [AW-1:0] res_addr;
  logic [1:0]    res_status;

  logic [AW-1:0] rd_s, rd_e;
  logic [CW-1:0] span, dst, ins_addr, rd_addr;
  logic [3:0]    lg;
  logic          lt_i, in_j, have_lo, have_hi, merged;
  logic [1:0]    n_calc;
  logic [AW:0]   sum;
  logic [AW-1:0] aend;

  assign rd_s = rd_data[2*AW-1:AW];
  assign rd_e = rd_data[AW-1:0];
  assign span = j - i;
  assign dst  = ptr + CW'(n) - span;
  assign ins_addr = i + CW'(q);
  assign rd_addr  = cmd.shift_rd ? ptr : k;
  assign sum  = {1'b0, b_r} + {1'b0, mask};
  assign aend = a_r + size;

  always_comb begin
    if (request.opcode == OP_ALLOC_ALIGN) lg = request.align_log2;
    else if (AW'(request.alloc_size) <= AW'(ALIGN_8)) lg = LG_8;
    else if (AW'(request.alloc_size) <= AW'(ALIGN_16)) lg = LG_16;
    else if (AW'(request.alloc_size) <= AW'(ALIGN_32)) lg = LG_32;
    else lg = LG_64;
  end

  always_comb begin
    lt_i    = (op == OP_FREE) ? (rd_e < s) : (rd_e <= s);
    in_j    = (op == OP_FREE) ? (rd_s <= e) : (rd_s < e);
    have_lo = cap_s < cut_lo;
    have_hi = cap_e > cut_hi;
    merged  = (span != '0);
    if (op == OP_FREE) n_calc = 2'd1;
    else n_calc = {1'b0, have_lo} + {1'b0, have_hi};
  end

  always_comb begin
    stat            = '0;
    stat.trivial    = !op[1] && (s >= e);
    stat.scan_end   = (k == count);
    stat.is_alloc   = op[1];
    stat.skip       = rd_e <= s;
    stat.stop       = rd_s >= e;
    stat.fit_ok     = !ovf && (a_r <= e_r) && ((e_r - a_r) >= size);
    stat.zero_size  = (size == '0);
    stat.nop        = (op == OP_RESERVE) && (span == '0);
    stat.full       = newcount > (CW+1)'(MAX_RANGES);
    stat.no_shift   = (CW'(n) == span) || (count == j);
    stat.shift_last = up ? (ptr == j) : (ptr == count - CW'(1));
    stat.ins_done   = (q == n);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.shift_rd) rd_data <= mem[rd_addr[IW-1:0]];
    if (cmd.shift_wr) begin
      mem[dst[IW-1:0]] <= rd_data;
    end else if (cmd.ins) begin
      mem[ins_addr[IW-1:0]] <= (q == 2'd0) ? {p0s, p0e} : {p1s, p1e};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= newcount[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= request.opcode;
      s          <= AW'(request.range_start);
      e          <= AW'(request.range_end);
      size       <= AW'(request.alloc_size);
      mask       <= (AW'(1) << lg) - AW'(1);
      k          <= '0;
      i          <= count;
      j          <= '0;
      i_found    <= 1'b0;
      cut_lo     <= AW'(request.range_start);
      cut_hi     <= AW'(request.range_end);
      res_addr   <= '0;
      res_status <= ST_OK;
    end
    if (cmd.scan_ev) begin
      if (!op[1] || stat.skip) k <= k + CW'(1);
      if (!op[1]) begin
        if (!lt_i && !i_found) begin
          i       <= k;
          i_found <= 1'b1;
          cap_s   <= rd_s;
        end
        if (in_j) begin
          j     <= k + CW'(1);
          cap_e <= rd_e;
        end
      end else begin
        i     <= k;
        j     <= k + CW'(1);
        cap_s <= rd_s;
        cap_e <= rd_e;
        b_r   <= (rd_s > s) ? rd_s : s;
        e_r   <= (rd_e < e) ? rd_e : e;
      end
    end
    if (cmd.fit_a) begin
      ovf <= sum[AW];
      a_r <= sum[AW-1:0] & ~mask;
    end
    if (cmd.fit_chk) begin
      if (!stat.fit_ok) begin
        k <= k + CW'(1);
      end else begin
        res_addr <= a_r;
        cut_lo   <= a_r;
        cut_hi   <= aend;
      end
    end
    if (cmd.prep) begin
      n        <= n_calc;
      q        <= 2'd0;
      newcount <= (CW+1)'(count) - (CW+1)'(span) + (CW+1)'(n_calc);
      up       <= CW'(n_calc) > span;
      ptr      <= (CW'(n_calc) > span) ? count - CW'(1) : j;
      if (op == OP_FREE) begin
        p0s <= (merged && cap_s < s) ? cap_s : s;
        p0e <= (merged && cap_e > e) ? cap_e : e;
      end else if (have_lo) begin
        p0s <= cap_s;
        p0e <= cut_lo;
      end else begin
        p0s <= cut_hi;
        p0e <= cap_e;
      end
      p1s <= cut_hi;
      p1e <= cap_e;
    end
    if (cmd.shift_wr) ptr <= up ? ptr - CW'(1) : ptr + CW'(1);
    if (cmd.ins) q <= q + 2'd1;
    if (cmd.nofit) begin
      res_addr   <= e;
      res_status <= ST_NOFIT;
    end
    if (cmd.full) begin
      res_addr   <= op[1] ? e : '0;
      res_status <= ST_FULL;
    end
  end

  assign result.address = res_addr;
  assign result.status  = res_status;

endmodule

[rtl/free_range_allocator.sv]
// channel   | ports                        | handshake
// ----------+------------------------------+------------------------------------
// request   | start, request, busy         | taken when start high, busy low
// result    | done, result                 | one cycle with done high, no stall
//
// an item scans the table entries, checks each candidate entry for a fit,
// moves entries when the table is spliced and then writes the new entries;
// the entries are read one at a time through the single read port of the
// range memory
// reset clears the controller and the entry count; the memory needs no clear
// busy stays high from the taking of an item until the cycle after done
module free_range_allocator import fra_pkg::*; #(
  parameter int MAX_RANGES = 128
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  fra_req_t request,
  output logic     busy,
  output logic     done,
  output fra_rsp_t result
);

  fra_cmd_t  cmd;
  fra_stat_t stat;

  fra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fra_datapath #(
    .MAX_RANGES (MAX_RANGES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

[rtl/fra_checker.sv]
module fra_checker import fra_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input fra_rsp_t result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("item taken but not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_NOFIT ||
              result.status == ST_FULL))
    else $error("bad status");

endmodule

bind free_range_allocator fra_checker u_fra_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import fra_pkg::*;

  localparam int NRANGE = 128;
  localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;
  localparam int WD_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  fra_req_t request = '0;
  logic     busy;
  logic     done;
  fra_rsp_t result;

  fra_rsp_t    expected_rsp[$];
  logic [47:0] free_lo[$];
  logic [47:0] free_hi[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          quiet = 0;

  free_range_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [1:0] table_splice(int lo, int hi, logic [47:0] ns[2],
                                              logic [47:0] ne[2], int n);
    if (free_lo.size() - (hi - lo) + n > NRANGE) return ST_FULL;
    for (int k = 0; k < hi - lo; k++) begin
      free_lo.delete(lo);
      free_hi.delete(lo);
    end
    for (int k = n - 1; k >= 0; k--) begin
      free_lo.insert(lo, ns[k]);
      free_hi.insert(lo, ne[k]);
    end
    return ST_OK;
  endfunction

  function automatic fra_rsp_t predict_range_op(fra_req_t r);
    fra_rsp_t    o;
    logic [47:0] ns[2], ne[2];
    logic [47:0] s, e, b, lim, msk, a;
    logic [48:0] sum;
    int i, j, n, cnt;
    o = '0;
    s = r.range_start;
    e = r.range_end;
    cnt = free_lo.size();
    n = 0;
    i = 0;
    if (r.opcode == OP_FREE) begin
      if (s < e) begin
        while (i < cnt && free_hi[i] < s) i++;
        j = i;
        while (j < cnt && free_lo[j] <= e) j++;
        ns[0] = s;
        ne[0] = e;
        if (j > i) begin
          if (free_lo[i] < s) ns[0] = free_lo[i];
          if (free_hi[j-1] > e) ne[0] = free_hi[j-1];
        end
        o.status = table_splice(i, j, ns, ne, 1);
      end
    end else if (r.opcode == OP_RESERVE) begin
      if (s < e) begin
        while (i < cnt && free_hi[i] <= s) i++;
        j = i;
        while (j < cnt && free_lo[j] < e) j++;
        if (j > i) begin
          if (free_lo[i] < s) begin
            ns[n] = free_lo[i]; ne[n] = s; n++;
          end
          if (free_hi[j-1] > e) begin
            ns[n] = e; ne[n] = free_hi[j-1]; n++;
          end
          o.status = table_splice(i, j, ns, ne, n);
        end
      end
    end else begin
      if (r.opcode == OP_ALLOC_ALIGN) msk = (48'd1 << r.align_log2) - 48'd1;
      else if (r.alloc_size <= ALIGN_8) msk = ALIGN_8 - 1;
      else if (r.alloc_size <= ALIGN_16) msk = ALIGN_16 - 1;
      else if (r.alloc_size <= ALIGN_32) msk = ALIGN_32 - 1;
      else msk = 48'd63;
      o.address = e;
      o.status = ST_NOFIT;
      while (i < cnt && free_hi[i] <= s) i++;
      for (; i < cnt && free_lo[i] < e; i++) begin
        b = free_lo[i] > s ? free_lo[i] : s;
        lim = free_hi[i] < e ? free_hi[i] : e;
        if (b > AMAX - msk) continue;
        a = (b + msk) & ~msk;
        if (a > lim || lim - a < r.alloc_size) continue;
        if (r.alloc_size == 0) begin
          o.address = a;
          o.status = ST_OK;
          break;
        end
        sum = a + r.alloc_size;
        if (free_lo[i] < a) begin
          ns[n] = free_lo[i]; ne[n] = a; n++;
        end
        if (free_hi[i] > sum[47:0]) begin
          ns[n] = sum[47:0]; ne[n] = free_hi[i]; n++;
        end
        o.status = table_splice(i, i + 1, ns, ne, n);
        if (o.status == ST_OK) o.address = a;
        break;
      end
    end
    return o;
  endfunction

  task automatic send_item(fra_req_t r);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(predict_range_op(r));
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    fra_rsp_t x;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $error("result with no item pending: address %h status %0d",
               result.address, result.status);
        errors++;
      end else begin
        x = expected_rsp.pop_front();
        if (result.address !== x.address) begin
          $error("address expected %h actual %h", x.address, result.address);
          errors++;
        end
        if (result.status !== x.status) begin
          $error("status expected %0d actual %0d", x.status, result.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [47:0] rand_addr(int mode);
    case (mode)
      0: return {$urandom, $urandom} & AMAX;
      1: return AMAX - $urandom_range(200);
      default: return 48'($urandom_range(4095));
    endcase
  endfunction

  function automatic fra_req_t make_req(logic [1:0] op, logic [47:0] s,
                                        logic [47:0] e, logic [47:0] sz,
                                        logic [3:0] lg);
    fra_req_t r;
    r.opcode = op;
    r.range_start = s;
    r.range_end = e;
    r.alloc_size = sz;
    r.align_log2 = lg;
    return r;
  endfunction

  task automatic test_directed();
    send_item(make_req(OP_ALLOC_AUTO, 0, AMAX, 8, 0));
    send_item(make_req(OP_FREE, 100, 100, 0, 0));
    send_item(make_req(OP_FREE, 200, 100, 0, 0));
    send_item(make_req(OP_FREE, 0, 4096, 0, 0));
    send_item(make_req(OP_FREE, 8192, 12288, 0, 0));
    send_item(make_req(OP_FREE, 4096, 8192, 0, 0));
    send_item(make_req(OP_RESERVE, 100, 300, 0, 0));
    send_item(make_req(OP_RESERVE, 50, 50, 0, 0));
    send_item(make_req(OP_ALLOC_AUTO, 0, AMAX, 5, 0));
    send_item(make_req(OP_ALLOC_AUTO, 0, AMAX, 16, 0));
    send_item(make_req(OP_ALLOC_AUTO, 0, AMAX, 30, 0));
    send_item(make_req(OP_ALLOC_AUTO, 0, AMAX, 100, 0));
    send_item(make_req(OP_ALLOC_ALIGN, 0, AMAX, 0, 4'd12));
    send_item(make_req(OP_ALLOC_ALIGN, 1, 9000, 7, 4'd0));
    send_item(make_req(OP_ALLOC_ALIGN, 500, 400, 7, 4'd15));
    send_item(make_req(OP_ALLOC_AUTO, 0, AMAX, AMAX, 0));
    send_item(make_req(OP_FREE, AMAX - 40, AMAX, 0, 0));
    send_item(make_req(OP_ALLOC_ALIGN, AMAX - 40, AMAX, 1, 4'd15));
    send_item(make_req(OP_ALLOC_AUTO, AMAX - 40, AMAX, 1, 0));
    send_item(make_req(OP_RESERVE, 0, AMAX, 0, 0));
    send_item(make_req(OP_FREE, AMAX, 0, 0, 0));
  endtask

  task automatic test_table_full();
    for (int k = 0; k < NRANGE + 2; k++)
      send_item(make_req(OP_FREE, 48'(k * 16), 48'(k * 16 + 8), 0, 0));
    send_item(make_req(OP_RESERVE, 1, 2, 0, 0));
    send_item(make_req(OP_ALLOC_ALIGN, 0, AMAX, 1, 4'd1));
    send_item(make_req(OP_ALLOC_ALIGN, 0, AMAX, 8, 4'd3));
    send_item(make_req(OP_RESERVE, 0, AMAX, 0, 0));
  endtask

  task automatic test_random(int count, int pct);
    fra_req_t r;
    logic [47:0] s, e;
    idle_pct = pct;
    for (int k = 0; k < count; k++) begin
      s = rand_addr($urandom_range(5) < 4 ? 2 : $urandom_range(1));
      e = $urandom_range(9) < 8 ? s + 48'($urandom_range(600)) : rand_addr($urandom_range(2));
      r.opcode = 2'($urandom_range(3));
      r.range_start = r.opcode[1] && $urandom_range(1) ? s & 48'h3ff : s;
      r.range_end = r.opcode[1] && $urandom_range(1) ? AMAX - 48'($urandom_range(1)) : e;
      case ($urandom_range(7))
        0: r.alloc_size = rand_addr(0);
        1: r.alloc_size = 0;
        default: r.alloc_size = 48'($urandom_range(80));
      endcase
      r.align_log2 = $urandom_range(9) == 0 ? 4'($urandom) : 4'($urandom_range(12));
      send_item(r);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(290, 0);
    test_random(290, 53);
    test_random(290, 53);
    test_random(290, 6);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[free_range_allocator.f]
rtl/fra_pkg.sv
rtl/fra_ctrl.sv
rtl/fra_datapath.sv
rtl/free_range_allocator.sv
rtl/fra_checker.sv
tb/sv/testbench.sv
